/* rtl/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// shared widths, types and codes of the periodic message scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

   localparam int MAX_SLOTS   = 32;
   localparam int TIME_BITS   = 48;
   localparam int PERIOD_BITS = 24;
   localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
   localparam int CNT_BITS    = $clog2(MAX_SLOTS + 1);
   localparam int CFG_BITS    = 6;
   localparam int ENTRY_BITS  = PERIOD_BITS + TIME_BITS;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef logic [TIME_BITS-1:0]   time_type;
   typedef logic [PERIOD_BITS-1:0] period_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;

   typedef struct packed {
      period_type period;
      time_type   due;
   } entry_type;

   typedef struct packed {
      logic     hit;
      time_type next_due;
   } eval_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

/* rtl/pms_ram.sv */
// ----------------------------------------------------------------------------
// pms_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/pms_eval.sv */
// ----------------------------------------------------------------------------
// pms_eval
// due check and next due time of one slot, saturating at the time maximum
// ----------------------------------------------------------------------------
`default_nettype none

module pms_eval
   import pms_pkg::*;
(
   input  wire entry_type entry,
   input  wire time_type  now,
   output eval_type       result
);

   localparam time_type TIME_MAX = '1;

   logic [TIME_BITS:0] adv_sum;
   logic [TIME_BITS:0] sync_sum;
   time_type           adv;
   time_type           resync;

   always_comb begin
      adv_sum  = {1'b0, entry.due} + {{(TIME_BITS + 1 - PERIOD_BITS){1'b0}}, entry.period};
      sync_sum = {1'b0, now} + {{(TIME_BITS + 1 - PERIOD_BITS){1'b0}}, entry.period};
      adv      = adv_sum[TIME_BITS] ? TIME_MAX : adv_sum[TIME_BITS-1:0];
      resync   = sync_sum[TIME_BITS] ? TIME_MAX : sync_sum[TIME_BITS-1:0];
      result.hit      = (entry.period != '0) && (now >= entry.due);
      result.next_due = (adv <= now) ? resync : adv;
   end

endmodule

`default_nettype wire

/* rtl/periodic_message_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// periodic_message_scheduler_unit
// slot table with periods and due times, scanned on every time tick
// ----------------------------------------------------------------------------
// A load beat writes a slot's period and clears its due time. A tick beat
// scans slots 0 .. active_slots-1 (at most 32) through the slot memory at
// one read per cycle while not stalled; the scan stalls while the result
// side holds off a due slot and an earlier due slot still waits. The rsp
// beat for a due slot leaves once the next due slot is found or the scan
// ends, which sets last. Slots never loaded since reset read as disabled.
`default_nettype none

module periodic_message_scheduler_unit
   import pms_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_operation,
   input  wire logic [SLOT_BITS-1:0]   req_slot,
   input  wire logic [PERIOD_BITS-1:0] req_period_us,
   input  wire logic [TIME_BITS-1:0]   req_now_us,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [SLOT_BITS-1:0]        rsp_due_slot,
   output logic                        rsp_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CFG_BITS-1:0]    csr_active_slots
);

   state_type             state_ff, state_in;
   logic [CFG_BITS-1:0]   active_ff, active_in;
   logic [MAX_SLOTS-1:0]  valid_ff, valid_in;
   time_type              now_ff, now_in;
   cnt_type               lim_ff, lim_in;
   cnt_type               scan_idx_ff, scan_idx_in;
   slot_type              eval_idx_ff, eval_idx_in;
   logic                  eval_valid_ff, eval_valid_in;
   slot_type              pend_idx_ff, pend_idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   slot_type              rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic      accept;
   logic      out_free;
   logic      stall;
   logic      issue;
   logic      push;
   logic      push_last;
   logic      scan_hit;
   logic      wr_en;
   slot_type  wr_addr;
   entry_type wr_data;
   slot_type  rd_addr;
   entry_type rd_raw;
   entry_type rd_entry;
   eval_type  ev;

   pms_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = valid_ff[eval_idx_ff] ? rd_raw : '0;

   pms_eval u_eval (
      .entry  (rd_entry),
      .now    (now_ff),
      .result (ev)
   );

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_hit  = (state_ff == ST_SCAN) && eval_valid_ff && ev.hit;
   assign stall     = scan_hit && pend_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((scan_idx_ff >= lim_ff) && !stall) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      push      = 1'b0;
      push_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            issue = !stall && (scan_idx_ff < lim_ff);
            push  = scan_hit && pend_valid_ff && out_free;
         end
         ST_FLUSH: begin
            push      = pend_valid_ff && out_free;
            push_last = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // memory access
   always_comb begin
      rd_addr = stall ? eval_idx_ff : scan_idx_ff[SLOT_BITS-1:0];
      wr_en   = 1'b0;
      wr_addr = eval_idx_ff;
      wr_data = '{period: rd_entry.period, due: ev.next_due};
      if (accept && (req_operation == OP_LOAD)) begin
         wr_en   = 1'b1;
         wr_addr = req_slot;
         wr_data = '{period: req_period_us, due: '0};
      end else if (scan_hit && !stall) begin
         wr_en = 1'b1;
      end
   end

   // datapath next values
   always_comb begin
      active_in     = csr_valid ? csr_active_slots : active_ff;
      valid_in      = valid_ff;
      now_in        = now_ff;
      lim_in        = lim_ff;
      scan_idx_in   = scan_idx_ff;
      eval_idx_in   = eval_idx_ff;
      eval_valid_in = eval_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept && (req_operation == OP_LOAD)) begin
         valid_in[req_slot] = 1'b1;
      end
      if (accept && (req_operation == OP_TICK)) begin
         now_in        = req_now_us;
         lim_in        = (active_ff > CFG_BITS'(MAX_SLOTS)) ? cnt_type'(MAX_SLOTS)
                                                            : cnt_type'(active_ff);
         scan_idx_in   = '0;
         eval_valid_in = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (state_ff == ST_SCAN) begin
         if (!stall) begin
            eval_valid_in = issue;
         end
         if (issue) begin
            eval_idx_in = scan_idx_ff[SLOT_BITS-1:0];
            scan_idx_in = scan_idx_ff + cnt_type'(1);
         end
         if (scan_hit && !stall) begin
            pend_idx_in   = eval_idx_ff;
            pend_valid_in = 1'b1;
         end
      end

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = pend_idx_ff;
         rsp_last_in  = push_last;
      end
      if ((state_ff == ST_FLUSH) && push) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         valid_ff      <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         valid_ff      <= valid_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      lim_ff      <= lim_in;
      scan_idx_ff <= scan_idx_in;
      eval_idx_ff <= eval_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_due_slot = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

/* tb/tb_periodic_message_scheduler_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_message_scheduler_unit
// self-checking bench for the periodic message scheduler
// ----------------------------------------------------------------------------
// Loads slot periods and sends time ticks through the req channel while a
// local slot table predicts which slots fall due on each tick. Every rsp beat
// is compared against the oldest predicted due slot. Directed tests cover
// reset state, disabled slots, resync of late slots, the active slot limit
// and saturated due times; random traffic, a long result stall, paced ticks
// and a final burst with no idling follow.
// ----------------------------------------------------------------------------

module tb_periodic_message_scheduler_unit;
   import pms_pkg::*;

   localparam int       CLK_PERIOD  = 4;
   localparam int       CYCLE_LIMIT = 1000000;
   localparam int       SETTLE      = 48;
   localparam time_type TIME_MAX    = '1;

   typedef struct {
      slot_type slot;
      logic     last;
   } due_beat_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   slot_type             req_slot;
   period_type           req_period_us;
   time_type             req_now_us;
   logic                 rsp_valid;
   logic                 rsp_ready;
   slot_type             rsp_due_slot;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CFG_BITS-1:0]  csr_active_slots;

   // predicted slot table
   period_type           slot_period [MAX_SLOTS];
   time_type             slot_due [MAX_SLOTS];
   logic [CFG_BITS-1:0]  scan_limit;
   due_beat_type         pending_due [$];

   time_type             run_now_us;
   int                   mismatch_count;
   int                   cycle_count;
   int                   rsp_hold_len;
   bit                   send_gaps;
   bit                   recv_gaps;

   periodic_message_scheduler_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_slot         (req_slot),
      .req_period_us    (req_period_us),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_due_slot     (rsp_due_slot),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_slots (csr_active_slots)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic time_type add_sat(input time_type a, input time_type b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   function automatic void load_slot(input slot_type slot, input period_type period);
      slot_period[slot] = period;
      slot_due[slot]    = '0;
   endfunction

   function automatic void scan_tick(input time_type now_us);
      int       lim;
      time_type next_due;
      slot_type hits [$];
      lim = (scan_limit > MAX_SLOTS) ? MAX_SLOTS : int'(scan_limit);
      for (int i = 0; i < lim; i++) begin
         if (slot_period[i] != '0 && now_us >= slot_due[i]) begin
            hits.push_back(slot_type'(i));
            next_due = add_sat(slot_due[i], time_type'(slot_period[i]));
            if (next_due <= now_us) begin
               next_due = add_sat(now_us, time_type'(slot_period[i]));
            end
            slot_due[i] = next_due;
         end
      end
      foreach (hits[k]) begin
         pending_due.push_back('{slot: hits[k], last: (k == hits.size() - 1)});
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_item(input logic op, input slot_type slot,
                            input period_type period, input time_type now_us);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_slot      <= slot;
      req_period_us <= period;
      req_now_us    <= now_us;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) begin
         load_slot(slot, period);
      end else begin
         scan_tick(now_us);
      end
   endtask

   task automatic quiesce(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_active_slots(input logic [CFG_BITS-1:0] value);
      quiesce(SETTLE);
      csr_valid        <= 1'b1;
      csr_active_slots <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scan_limit = value;
   endtask

   task automatic send_random_item();
      int unsigned pick;
      period_type  period;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         period = ($urandom_range(0, 9) == 0) ? period_type'($urandom)
                                              : period_type'($urandom_range(0, 60));
         send_item(OP_LOAD, slot_type'($urandom), period, time_type'({$urandom, $urandom}));
      end else if (pick < 95) begin
         run_now_us = run_now_us + time_type'($urandom_range(0, 40));
         send_item(OP_TICK, slot_type'($urandom), period_type'($urandom), run_now_us);
      end else begin
         // stray time, may jump far ahead or back
         send_item(OP_TICK, slot_type'($urandom), period_type'($urandom),
                   time_type'({$urandom, $urandom}));
      end
   endtask

   task automatic test_reset_state();
      send_item(OP_TICK, '0, '0, '0);
      write_active_slots(6'd32);
      send_item(OP_TICK, '0, '0, '0);
   endtask

   task automatic test_load_and_tick();
      send_item(OP_LOAD, 5'd0, 24'd1, '0);
      send_item(OP_LOAD, 5'd31, 24'hFFFFFF, '0);
      send_item(OP_LOAD, 5'd5, 24'd10, '0);
      send_item(OP_TICK, '0, '0, time_type'(0));
      send_item(OP_TICK, '0, '0, time_type'(1));
      send_item(OP_TICK, '0, '0, time_type'(10));
   endtask

   task automatic test_resync_behind();
      send_item(OP_TICK, 5'd31, 24'hFFFFFF, time_type'(5000));
   endtask

   task automatic test_disable_slot();
      send_item(OP_LOAD, 5'd0, '0, TIME_MAX);
      send_item(OP_TICK, '0, '0, time_type'(6000));
   endtask

   task automatic test_active_limit();
      write_active_slots(6'd1);
      send_item(OP_TICK, '0, '0, time_type'(7000));
      write_active_slots(6'd63);
      send_item(OP_TICK, '0, '0, time_type'(20000000));
      write_active_slots(6'd0);
      send_item(OP_TICK, '0, '0, time_type'(30000000));
   endtask

   task automatic test_due_saturation();
      write_active_slots(6'd32);
      send_item(OP_LOAD, 5'd3, 24'hFFFFFF, '0);
      send_item(OP_TICK, '0, '0, TIME_MAX - 10);
      send_item(OP_TICK, '0, '0, TIME_MAX);
      send_item(OP_TICK, '0, '0, TIME_MAX);
   endtask

   task automatic test_random_traffic();
      logic [CFG_BITS-1:0] cfg;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: cfg = 6'd32;
            1: cfg = CFG_BITS'($urandom_range(1, 31));
            2: cfg = 6'd63;
            3: cfg = CFG_BITS'($urandom_range(33, 62));
            default: cfg = CFG_BITS'($urandom_range(0, 63));
         endcase
         write_active_slots(cfg);
         repeat (45) send_random_item();
      end
   endtask

   task automatic test_output_backpressure();
      write_active_slots(6'd32);
      send_gaps    = 1'b0;
      rsp_hold_len = 400;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         send_item(OP_LOAD, slot_type'(i), 24'd1, time_type'({$urandom, $urandom}));
      end
      repeat (16) begin
         run_now_us = run_now_us + 1;
         send_item(OP_TICK, slot_type'($urandom), period_type'($urandom), run_now_us);
      end
      send_gaps = 1'b1;
   endtask

   task automatic test_paced_ticks();
      write_active_slots(CFG_BITS'($urandom_range(0, 63)));
      repeat (20) begin
         send_random_item();
         quiesce(0);
      end
   endtask

   task automatic test_final_burst();
      write_active_slots(6'd32);
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      repeat (50) send_random_item();
   endtask

   // result side
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      due_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_due.size() == 0) begin
            report_mismatch("unexpected rsp beat, due_slot", rsp_due_slot, -1);
         end else begin
            want = pending_due.pop_front();
            if (rsp_due_slot !== want.slot) begin
               report_mismatch("due_slot", rsp_due_slot, want.slot);
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_LOAD;
      req_slot         = '0;
      req_period_us    = '0;
      req_now_us       = '0;
      csr_valid        = 1'b0;
      csr_active_slots = '0;
      rsp_hold_len     = 0;
      send_gaps        = 1'b1;
      recv_gaps        = 1'b1;
      mismatch_count   = 0;
      run_now_us       = '0;
      scan_limit       = '0;
      foreach (slot_period[i]) begin
         slot_period[i] = '0;
         slot_due[i]    = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load_and_tick();
      test_resync_behind();
      test_disable_slot();
      test_active_limit();
      test_due_saturation();
      test_random_traffic();
      test_output_backpressure();
      test_paced_ticks();
      test_final_burst();

      quiesce(SETTLE);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
